// ----- src/tlfq_pkg.sv -----
// Shared constants, codes and controller/datapath link types for the
// two-level feedback queue scheduler. No dependencies.
package tlfq_pkg;

    localparam int MAX_TASKS   = 64;
    localparam int QUEUE_DEPTH = 64;

    localparam int TASK_W    = 6;
    localparam int ACT_W     = 3;
    localparam int KIND_W    = 3;
    localparam int SLICE_W   = 40;
    localparam int CFG_IDX_W = 1;

    localparam int TASK_IX_W = $clog2(MAX_TASKS);
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    // action codes
    localparam logic [ACT_W-1:0] ACT_ENABLE   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ENQUEUE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DISPATCH = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RUNNING  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_STOPPING = 3'd4;
    localparam logic [ACT_W-1:0] ACT_WAKE     = 3'd5;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DONE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP_TOP = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_BOT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIRECT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FULL    = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_SLICE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOT_SLICE = 1'd1;

    localparam logic [SLICE_W-1:0] TOP_SLICE_RST = 40'd50000000;
    localparam logic [SLICE_W-1:0] BOT_SLICE_RST = 40'd200000000;

    typedef struct packed {
        logic capture;  // latch the incoming beat
        logic exec;     // evaluate the latched event
        logic finish;   // emit the result of a queue pop
    } t_cmd;

    typedef struct packed {
        logic need_pop; // latched event pops a queue entry
    } t_status;

endpackage

// ----- src/two_level_feedback_queue_scheduler_top.sv -----
// Top level of the two-level feedback queue scheduler.
// Depends on tlfq_pkg, tlfq_ctrl and tlfq_dp.
//
//   channel   | handshake        | payload
//   ----------+------------------+-------------------------------------------
//   event in  | start && !busy   | i_action, i_task_id, i_cpu_idle
//   result    | o_valid (1 cyc)  | o_result_kind, o_out_task, o_out_slice_ns,
//             |                  | o_out_level
//   config    | i_cfg_we         | i_cfg_idx, i_cfg_data
//
// An event beat is evaluated in the cycle after it is taken; its result shows
// on o_valid the cycle after that. A dispatch that pops a queue first passes
// through the ST_POP state for the registered queue memory read.
// busy drops while the result strobes, so the next beat can be taken then.
// Reset is synchronous, active low; it clears all task flags and queue counts.
// The receiver cannot stall: each result beat lasts exactly one cycle.
module two_level_feedback_queue_scheduler_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [tlfq_pkg::ACT_W-1:0]        i_action,
    input  logic [tlfq_pkg::TASK_W-1:0]       i_task_id,
    input  logic                              i_cpu_idle,
    input  logic                              i_cfg_we,
    input  logic [tlfq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tlfq_pkg::SLICE_W-1:0]      i_cfg_data,
    output logic                              o_valid,
    output logic [tlfq_pkg::KIND_W-1:0]       o_result_kind,
    output logic [tlfq_pkg::TASK_W-1:0]       o_out_task,
    output logic [tlfq_pkg::SLICE_W-1:0]      o_out_slice_ns,
    output logic                              o_out_level
);

    tlfq_pkg::t_cmd    cmd;
    tlfq_pkg::t_status status;

    tlfq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tlfq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_action       (i_action),
        .i_task_id      (i_task_id),
        .i_cpu_idle     (i_cpu_idle),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_result_kind  (o_result_kind),
        .o_out_task     (o_out_task),
        .o_out_slice_ns (o_out_slice_ns),
        .o_out_level    (o_out_level)
    );

endmodule

// ----- src/tlfq_fifo.sv -----
// Task id FIFO: circular buffer memory with head/tail/count.
// Depends on tlfq_pkg. Read data is registered in r_rdata when i_pop is high.
module tlfq_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [tlfq_pkg::TASK_W-1:0]   i_wdata,
    input  logic                          i_pop,
    output logic [tlfq_pkg::TASK_W-1:0]   o_rdata,
    output logic                          o_empty,
    output logic                          o_full
);

    logic [tlfq_pkg::TASK_W-1:0] r_mem [tlfq_pkg::QUEUE_DEPTH];
    logic [tlfq_pkg::TASK_W-1:0] r_rdata;
    logic [tlfq_pkg::QPTR_W-1:0] r_head, n_head;
    logic [tlfq_pkg::QPTR_W-1:0] r_tail, n_tail;
    logic [tlfq_pkg::QCNT_W-1:0] r_count, n_count;

    localparam logic [tlfq_pkg::QPTR_W-1:0] LAST_PTR =
        tlfq_pkg::QPTR_W'(tlfq_pkg::QUEUE_DEPTH - 1);
    localparam logic [tlfq_pkg::QCNT_W-1:0] FULL_CNT =
        tlfq_pkg::QCNT_W'(tlfq_pkg::QUEUE_DEPTH);

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_rdata = r_rdata;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail  = (r_tail == LAST_PTR) ? '0 : r_tail + 1'b1;
        end
        if (i_pop) begin
            n_head  = (r_head == LAST_PTR) ? '0 : r_head + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_wdata;
        end
        if (i_pop) begin
            r_rdata <= r_mem[r_head];
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("fifo count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && o_empty))
        else $error("fifo push on full or pop on empty");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("fifo count did not drop after pop");

endmodule

// ----- src/tlfq_ctrl.sv -----
// Controller FSM: sequences accept, evaluate and pop-completion steps.
// Depends on tlfq_pkg for the command and status types.
module tlfq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  tlfq_pkg::t_status i_status,
    output tlfq_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = i_status.need_pop ? ST_POP : ST_IDLE;
            end
            ST_POP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_cmd.capture  = (r_state == ST_IDLE) && start;
    assign o_cmd.exec     = (r_state == ST_EXEC);
    assign o_cmd.finish   = (r_state == ST_POP);

endmodule

// ----- src/tlfq_dp.sv -----
// Datapath: slice registers, per-task level/ran flags, both FIFOs, result register.
// Depends on tlfq_pkg and tlfq_fifo.
module tlfq_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tlfq_pkg::t_cmd                    i_cmd,
    output tlfq_pkg::t_status                 o_status,
    input  logic [tlfq_pkg::ACT_W-1:0]        i_action,
    input  logic [tlfq_pkg::TASK_W-1:0]       i_task_id,
    input  logic                              i_cpu_idle,
    input  logic                              i_cfg_we,
    input  logic [tlfq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tlfq_pkg::SLICE_W-1:0]      i_cfg_data,
    output logic                              o_valid,
    output logic [tlfq_pkg::KIND_W-1:0]       o_result_kind,
    output logic [tlfq_pkg::TASK_W-1:0]       o_out_task,
    output logic [tlfq_pkg::SLICE_W-1:0]      o_out_slice_ns,
    output logic                              o_out_level
);

    logic [tlfq_pkg::SLICE_W-1:0]   r_top_slice, r_bot_slice;
    logic [tlfq_pkg::MAX_TASKS-1:0] r_level, r_ran;

    // latched beat
    logic [tlfq_pkg::ACT_W-1:0]     r_action;
    logic [tlfq_pkg::TASK_W-1:0]    r_tid;
    logic [tlfq_pkg::TASK_IX_W-1:0] r_ix;
    logic                           r_idle;
    logic                           r_pop_lvl;

    // result register
    logic                           r_valid;
    logic [tlfq_pkg::KIND_W-1:0]    r_kind;
    logic [tlfq_pkg::TASK_W-1:0]    r_task;
    logic [tlfq_pkg::SLICE_W-1:0]   r_slice;
    logic                           r_lvl_out;

    logic                           cur_lvl, cur_ran;
    logic                           tbl_we, n_lvl_bit, n_ran_bit;
    logic                           push_top, push_bot, pop_top, pop_bot;
    logic                           top_empty, top_full, bot_empty, bot_full;
    logic [tlfq_pkg::TASK_W-1:0]    top_rdata, bot_rdata;
    logic [tlfq_pkg::KIND_W-1:0]    res_kind;
    logic [tlfq_pkg::TASK_W-1:0]    res_task;
    logic [tlfq_pkg::SLICE_W-1:0]   res_slice;
    logic                           res_lvl;

    tlfq_fifo u_top_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_top),
        .i_wdata (r_tid),
        .i_pop   (pop_top),
        .o_rdata (top_rdata),
        .o_empty (top_empty),
        .o_full  (top_full)
    );

    tlfq_fifo u_bot_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_bot),
        .i_wdata (r_tid),
        .i_pop   (pop_bot),
        .o_rdata (bot_rdata),
        .o_empty (bot_empty),
        .o_full  (bot_full)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_slice <= tlfq_pkg::TOP_SLICE_RST;
            r_bot_slice <= tlfq_pkg::BOT_SLICE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tlfq_pkg::CFG_TOP_SLICE: r_top_slice <= i_cfg_data;
                tlfq_pkg::CFG_BOT_SLICE: r_bot_slice <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_tid    <= i_task_id;
            r_ix     <= tlfq_pkg::TASK_IX_W'(32'(i_task_id) % tlfq_pkg::MAX_TASKS);
            r_idle   <= i_cpu_idle;
        end
        if (i_cmd.exec) begin
            r_pop_lvl <= top_empty;
        end
    end

    assign cur_lvl = r_level[r_ix];
    assign cur_ran = r_ran[r_ix];

    assign o_status.need_pop = (r_action == tlfq_pkg::ACT_DISPATCH) &&
                               !(top_empty && bot_empty);

    always_comb begin
        tbl_we    = 1'b0;
        n_lvl_bit = cur_lvl;
        n_ran_bit = cur_ran;
        push_top  = 1'b0;
        push_bot  = 1'b0;
        pop_top   = 1'b0;
        pop_bot   = 1'b0;
        res_kind  = tlfq_pkg::KIND_DONE;
        res_task  = r_tid;
        res_slice = '0;
        res_lvl   = cur_lvl;
        case (r_action)
            tlfq_pkg::ACT_ENABLE: begin
                tbl_we    = i_cmd.exec;
                n_lvl_bit = 1'b0;
                n_ran_bit = 1'b0;
                res_lvl   = 1'b0;
            end
            tlfq_pkg::ACT_ENQUEUE: begin
                if (cur_lvl ? bot_full : top_full) begin
                    res_kind = tlfq_pkg::KIND_FULL;
                end else begin
                    push_top = i_cmd.exec && !cur_lvl;
                    push_bot = i_cmd.exec && cur_lvl;
                end
            end
            tlfq_pkg::ACT_DISPATCH: begin
                pop_top  = i_cmd.exec && !top_empty;
                pop_bot  = i_cmd.exec && top_empty && !bot_empty;
                // both queues empty; otherwise the result comes after the read
                res_kind = tlfq_pkg::KIND_EMPTY;
                res_task = '0;
                res_lvl  = 1'b0;
            end
            tlfq_pkg::ACT_RUNNING: begin
                tbl_we = i_cmd.exec && !cur_lvl;
                n_ran_bit = 1'b1;
            end
            tlfq_pkg::ACT_STOPPING: begin
                // demote a top task to the bottom level once it has run
                tbl_we    = i_cmd.exec && !cur_lvl && cur_ran;
                n_lvl_bit = 1'b1;
                res_lvl   = cur_lvl | cur_ran;
            end
            tlfq_pkg::ACT_WAKE: begin
                if (r_idle) begin
                    res_kind  = tlfq_pkg::KIND_DIRECT;
                    res_slice = cur_lvl ? r_bot_slice : r_top_slice;
                end
            end
            default: begin
                res_task = '0;
                res_lvl  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_ran   <= '0;
        end else if (tbl_we) begin
            r_level[r_ix] <= n_lvl_bit;
            r_ran[r_ix]   <= n_ran_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.exec && !o_status.need_pop) || i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_kind    <= r_pop_lvl ? tlfq_pkg::KIND_POP_BOT : tlfq_pkg::KIND_POP_TOP;
            r_task    <= r_pop_lvl ? bot_rdata : top_rdata;
            r_slice   <= r_pop_lvl ? r_bot_slice : r_top_slice;
            r_lvl_out <= r_pop_lvl;
        end else if (i_cmd.exec) begin
            r_kind    <= res_kind;
            r_task    <= res_task;
            r_slice   <= res_slice;
            r_lvl_out <= res_lvl;
        end
    end

    assign o_valid        = r_valid;
    assign o_result_kind  = r_kind;
    assign o_out_task     = r_task;
    assign o_out_slice_ns = r_slice;
    assign o_out_level    = r_lvl_out;

endmodule
